// ----- src/rgg_pkg.sv -----
// ----------------------------------------------------------------------------
// rgg_pkg
// Shared types, constants and helpers for the rectilinear grid gradient block.
// ----------------------------------------------------------------------------
package rgg_pkg;

  // grid limits
  localparam int MAX_X = 32;
  localparam int MAX_Y = 32;
  localparam int MAX_Z = 32;

  // field widths
  localparam int CW  = 3;   // command
  localparam int IW  = 6;   // index_i / coord position
  localparam int JW  = 5;
  localparam int KW  = 5;
  localparam int NW  = 6;   // size registers
  localparam int DW  = 32;  // data
  localparam int STW = 2;

  // sample memory
  localparam int SDEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int SAW    = $clog2(SDEPTH);

  // coordinate memories (one entry past the last sample)
  localparam int CDEPTH = 33;
  localparam int CAW    = $clog2(CDEPTH);

  // divider
  localparam int FRAC  = 17;             // d * 2^17 / (2*span)
  localparam int DMW   = DW + 1;         // |d| magnitude
  localparam int SPW   = DW + 3;         // signed twice-span
  localparam int QW    = DMW + FRAC;     // dividend / quotient width
  localparam int DCW   = $clog2(QW);

  // commands
  localparam logic [CW-1:0] CMD_LDX   = 3'd0;
  localparam logic [CW-1:0] CMD_LDY   = 3'd1;
  localparam logic [CW-1:0] CMD_LDZ   = 3'd2;
  localparam logic [CW-1:0] CMD_LDS   = 3'd3;
  localparam logic [CW-1:0] CMD_QUERY = 3'd4;

  // status codes
  localparam logic [STW-1:0] ST_OK    = 2'd0;
  localparam logic [STW-1:0] ST_ZERO  = 2'd1;
  localparam logic [STW-1:0] ST_RANGE = 2'd2;
  localparam logic [STW-1:0] ST_SAT   = 2'd3;

  // axes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // register map (word index)
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_CELL   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       capture;    // latch input beat
    logic       exec;       // perform load / range check
    logic       rd;         // neighbor read sequence active
    logic [2:0] rd_cnt;
    logic [1:0] axis;
    logic       span_load;  // form difference and span, prime divider
    logic       div_step;
    logic       post;       // sign, saturate, store component
    logic       out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic query_ok;    // in-range query
    logic span_zero;
    logic is_3d;
    logic out_busy;    // result register full and stalled
  } dp_stat_t;

  // clamp a size register into lo..hi
  function automatic logic [NW-1:0] clamp_size(input logic [NW-1:0] v,
                                               input int lo, input int hi);
    logic [NW-1:0] r;
    if (int'(v) < lo)      r = NW'(lo);
    else if (int'(v) > hi) r = NW'(hi);
    else                   r = v;
    return r;
  endfunction

  // flat sample address
  function automatic logic [SAW-1:0] samp_addr(input logic [IW-1:0] i,
                                               input logic [JW-1:0] j,
                                               input logic [KW-1:0] k);
    return SAW'((int'(k) * MAX_Y + int'(j)) * MAX_X + int'(i));
  endfunction

endpackage

// ----- src/rgg_ctrl.sv -----
// ----------------------------------------------------------------------------
// rgg_ctrl
// Sequencer: load/query dispatch, neighbor reads, divide steps per axis.
// ----------------------------------------------------------------------------
module rgg_ctrl
  import rgg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_SPAN = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_POST = 8'b0010_0000,
    S_NEXT = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       rcnt_r, rcnt_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  logic [1:0]       axis_r, axis_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    rcnt_nxt  = rcnt_r;
    dcnt_nxt  = dcnt_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.rd_cnt = rcnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        axis_nxt = AX_X;
        rcnt_nxt = '0;
        state_nxt = stat.query_ok ? S_RD : S_FIN;
      end
      S_RD: begin
        cmd.rd   = 1'b1;
        rcnt_nxt = rcnt_r + 3'd1;
        if (rcnt_r == 3'd4) state_nxt = S_SPAN;
      end
      S_SPAN: begin
        cmd.span_load = 1'b1;
        dcnt_nxt      = '0;
        state_nxt     = stat.span_zero ? S_NEXT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(QW - 1)) state_nxt = S_POST;
      end
      S_POST: begin
        cmd.post  = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        rcnt_nxt = '0;
        if (axis_r == AX_X) begin
          axis_nxt  = AX_Y;
          state_nxt = S_RD;
        end else if (axis_r == AX_Y && stat.is_3d) begin
          axis_nxt  = AX_Z;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rcnt_r  <= '0;
      dcnt_r  <= '0;
      axis_r  <= AX_X;
    end else begin
      state_r <= state_nxt;
      rcnt_r  <= rcnt_nxt;
      dcnt_r  <= dcnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

// ----- src/rgg_dpath.sv -----
// ----------------------------------------------------------------------------
// rgg_dpath
// Stores, neighbor fetch, span/difference, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module rgg_dpath
  import rgg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  // item
  input  logic [CW-1:0]         in_command,
  input  logic [IW-1:0]         in_index_i,
  input  logic [JW-1:0]         in_index_j,
  input  logic [KW-1:0]         in_index_k,
  input  logic signed [DW-1:0]  in_value,
  // configuration
  input  logic [NW-1:0]         size_x,
  input  logic [NW-1:0]         size_y,
  input  logic [NW-1:0]         size_z,
  input  logic                  cell_centered,
  // result
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DW-1:0]  out_grad_x,
  output logic signed [DW-1:0]  out_grad_y,
  output logic signed [DW-1:0]  out_grad_z,
  output logic [STW-1:0]        out_status
);

  // stores
  logic [DW-1:0] smem [SDEPTH];
  logic [DW-1:0] xmem [CDEPTH];
  logic [DW-1:0] ymem [CDEPTH];
  logic [DW-1:0] zmem [CDEPTH];

  // latched item
  logic [CW-1:0]  cmd_r;
  logic [IW-1:0]  ii_r;
  logic [JW-1:0]  jj_r;
  logic [KW-1:0]  kk_r;
  logic [DW-1:0]  val_r;

  // fetch
  logic [DW-1:0]  sdat_r, cxd_r, cyd_r, czd_r;
  logic [DW-1:0]  slo_r, shi_r, c0_r, c1_r, c2_r, c3_r;

  // divider
  logic [SPW-1:0] rem_r;
  logic [SPW-1:0] dvs_r;
  logic [QW-1:0]  dq_r;
  logic           neg_r;

  // accumulated result
  logic [DW-1:0]  gx_r, gy_r, gz_r;
  logic           zero_r, sat_r, rng_r;

  // output register
  logic           ov_r;
  logic [DW-1:0]  ogx_r, ogy_r, ogz_r;
  logic [STW-1:0] ost_r;

  // clamped sizes
  logic [NW-1:0] nx, ny, nz;
  assign nx = clamp_size(size_x, 2, MAX_X);
  assign ny = clamp_size(size_y, 2, MAX_Y);
  assign nz = clamp_size(size_z, 1, MAX_Z);

  logic q_range_bad;
  assign q_range_bad = (NW'(ii_r) >= nx) || (NW'(jj_r) >= ny) || (NW'(kk_r) >= nz);

  // neighbor positions on the current axis
  logic [NW-1:0] pos, n_ax, lo, hi;
  always_comb begin
    case (cmd.axis)
      AX_X:    begin pos = NW'(ii_r); n_ax = nx; end
      AX_Y:    begin pos = NW'(jj_r); n_ax = ny; end
      default: begin pos = NW'(kk_r); n_ax = nz; end
    endcase
    if (pos == '0) begin
      lo = '0;
      hi = NW'(1);
    end else if (pos == n_ax - NW'(1)) begin
      lo = n_ax - NW'(2);
      hi = n_ax - NW'(1);
    end else begin
      lo = pos - NW'(1);
      hi = pos + NW'(1);
    end
  end

  // read addresses by sequence step
  logic [NW-1:0]  sp, cp;
  logic [SAW-1:0] saddr;
  always_comb begin
    sp = (cmd.rd_cnt == 3'd0) ? lo : hi;
    case (cmd.rd_cnt)
      3'd0:    cp = lo;
      3'd1:    cp = lo + NW'(1);
      3'd2:    cp = hi;
      default: cp = hi + NW'(1);
    endcase
    case (cmd.axis)
      AX_X:    saddr = samp_addr(IW'(sp), jj_r, kk_r);
      AX_Y:    saddr = samp_addr(ii_r, JW'(sp), kk_r);
      default: saddr = samp_addr(ii_r, jj_r, KW'(sp));
    endcase
  end

  logic [DW-1:0] cdat;
  always_comb begin
    case (cmd.axis)
      AX_X:    cdat = cxd_r;
      AX_Y:    cdat = cyd_r;
      default: cdat = czd_r;
    endcase
  end

  // load decode
  logic wr_x, wr_y, wr_z, wr_s, ld_bad;
  always_comb begin
    wr_x = 1'b0; wr_y = 1'b0; wr_z = 1'b0; wr_s = 1'b0; ld_bad = 1'b0;
    if (cmd.exec) begin
      case (cmd_r)
        CMD_LDX: if (int'(ii_r) <= MAX_X) wr_x = 1'b1; else ld_bad = 1'b1;
        CMD_LDY: if (int'(ii_r) <= MAX_Y) wr_y = 1'b1; else ld_bad = 1'b1;
        CMD_LDZ: if (int'(ii_r) <= MAX_Z) wr_z = 1'b1; else ld_bad = 1'b1;
        CMD_LDS: begin
          if (int'(ii_r) < MAX_X && int'(jj_r) < MAX_Y && int'(kk_r) < MAX_Z)
            wr_s = 1'b1;
          else
            ld_bad = 1'b1;
        end
        CMD_QUERY: ld_bad = q_range_bad;
        default:   ld_bad = 1'b0;
      endcase
    end
  end

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_s) smem[samp_addr(ii_r, jj_r, kk_r)] <= val_r;
    sdat_r <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    if (wr_x) xmem[CAW'(ii_r)] <= val_r;
    if (wr_y) ymem[CAW'(ii_r)] <= val_r;
    if (wr_z) zmem[CAW'(ii_r)] <= val_r;
    cxd_r <= xmem[CAW'(cp)];
    cyd_r <= ymem[CAW'(cp)];
    czd_r <= zmem[CAW'(cp)];
  end

  // difference and twice-span
  logic signed [DMW-1:0] dif;
  logic signed [SPW-1:0] span2;
  logic [DMW-1:0]        dmag;
  logic [SPW-1:0]        smag;
  always_comb begin
    dif = DMW'($signed(shi_r)) - DMW'($signed(slo_r));
    if (cell_centered)
      span2 = (SPW'($signed(c2_r)) + SPW'($signed(c3_r)))
            - (SPW'($signed(c0_r)) + SPW'($signed(c1_r)));
    else
      span2 = (SPW'($signed(c2_r)) - SPW'($signed(c0_r))) <<< 1;
    dmag = dif[DMW-1]   ? DMW'(-dif)   : DMW'(dif);
    smag = span2[SPW-1] ? SPW'(-span2) : SPW'(span2);
  end

  // one restoring divide step
  logic [SPW:0]   trial_sh;
  logic           q_bit;
  logic [SPW:0]   trial_sub;
  assign trial_sh  = {rem_r, dq_r[QW-1]};
  assign trial_sub = trial_sh - {1'b0, dvs_r};
  assign q_bit     = (trial_sh >= {1'b0, dvs_r});

  // sign and saturate the quotient
  logic [DW-1:0] comp;
  logic          comp_sat;
  always_comb begin
    comp_sat = 1'b0;
    if (neg_r) begin
      if (dq_r > QW'(64'h8000_0000)) begin
        comp = 32'h8000_0000; comp_sat = 1'b1;
      end else begin
        comp = DW'(-dq_r);
      end
    end else begin
      if (dq_r > QW'(64'h7FFF_FFFF)) begin
        comp = 32'h7FFF_FFFF; comp_sat = 1'b1;
      end else begin
        comp = DW'(dq_r);
      end
    end
  end

  // item, fetch and divider registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      ii_r  <= in_index_i;
      jj_r  <= in_index_j;
      kk_r  <= in_index_k;
      val_r <= in_value;
    end
    if (cmd.rd) begin
      case (cmd.rd_cnt)
        3'd1:    begin slo_r <= sdat_r; c0_r <= cdat; end
        3'd2:    begin shi_r <= sdat_r; c1_r <= cdat; end
        3'd3:    c2_r <= cdat;
        3'd4:    c3_r <= cdat;
        default: ;
      endcase
    end
    if (cmd.span_load) begin
      rem_r <= '0;
      dvs_r <= smag;
      dq_r  <= {dmag, {FRAC{1'b0}}};
      neg_r <= dif[DMW-1] ^ span2[SPW-1];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? trial_sub[SPW-1:0] : trial_sh[SPW-1:0];
      dq_r  <= {dq_r[QW-2:0], q_bit};
    end
  end

  // per-query result and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= 1'b0;
      sat_r  <= 1'b0;
      rng_r  <= 1'b0;
    end else if (cmd.capture) begin
      zero_r <= 1'b0;
      sat_r  <= 1'b0;
      rng_r  <= 1'b0;
    end else begin
      if (cmd.exec && ld_bad) rng_r <= 1'b1;
      if (cmd.span_load && span2 == '0) zero_r <= 1'b1;
      if (cmd.post && comp_sat) sat_r <= 1'b1;
    end
  end

  logic [DW-1:0] cval;
  logic          cwr;
  assign cwr  = cmd.post || (cmd.span_load && span2 == '0);
  assign cval = cmd.post ? comp : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gx_r <= '0;
      gy_r <= '0;
      gz_r <= '0;
    end else if (cwr) begin
      case (cmd.axis)
        AX_X:    gx_r <= cval;
        AX_Y:    gy_r <= cval;
        default: gz_r <= cval;
      endcase
    end
  end

  // result register
  logic [STW-1:0] st_fin;
  assign st_fin = rng_r ? ST_RANGE : (zero_r ? ST_ZERO : (sat_r ? ST_SAT : ST_OK));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ogx_r <= gx_r;
      ogy_r <= gy_r;
      ogz_r <= gz_r;
      ost_r <= st_fin;
    end
  end

  assign out_valid  = ov_r;
  assign out_grad_x = ogx_r;
  assign out_grad_y = ogy_r;
  assign out_grad_z = ogz_r;
  assign out_status = ost_r;

  assign stat.query_ok  = (cmd_r == CMD_QUERY) && !q_range_bad;
  assign stat.span_zero = (span2 == '0);
  assign stat.is_3d     = (nz > NW'(1));
  assign stat.out_busy  = ov_r && out_stall;

endmodule

// ----- src/rectilinear_grid_gradient.sv -----
// Sequence: a load or rejected query goes from accept through execute and finish
//   to the result register; a query runs, per axis, neighbor fetch, span, divide,
//   post and next-axis steps, and a zero-span axis skips the divide and post.
// Throughput: one item at a time; the finish step waits while the result register is stalled.
// Reset: synchronous active-low rst_n clears control and config to defaults;
//   stores are undefined until written.
// ----------------------------------------------------------------------------
// rectilinear_grid_gradient
// Central-difference gradient (one-sided at the edges) on a rectilinear grid with APB configuration.
// ----------------------------------------------------------------------------
module rectilinear_grid_gradient
  import rgg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CW-1:0]         in_command,
  input  logic [IW-1:0]         in_index_i,
  input  logic [JW-1:0]         in_index_j,
  input  logic [KW-1:0]         in_index_k,
  input  logic signed [DW-1:0]  in_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DW-1:0]  out_grad_x,
  output logic signed [DW-1:0]  out_grad_y,
  output logic signed [DW-1:0]  out_grad_z,
  output logic [STW-1:0]        out_status,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [NW-1:0] size_x_r, size_y_r, size_z_r;
  logic          cell_r;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= NW'(32);
      size_y_r <= NW'(32);
      size_z_r <= NW'(1);
      cell_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SIZE_X: size_x_r <= pwdata[NW-1:0];
        REG_SIZE_Y: size_y_r <= pwdata[NW-1:0];
        REG_SIZE_Z: size_z_r <= pwdata[NW-1:0];
        REG_CELL:   cell_r   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (reg_idx)
      REG_SIZE_X: prdata = 32'(size_x_r);
      REG_SIZE_Y: prdata = 32'(size_y_r);
      REG_SIZE_Z: prdata = 32'(size_z_r);
      REG_CELL:   prdata = 32'(cell_r);
      default:    prdata = '0;
    endcase
  end

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rgg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rgg_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_command),
    .in_index_i    (in_index_i),
    .in_index_j    (in_index_j),
    .in_index_k    (in_index_k),
    .in_value      (in_value),
    .size_x        (size_x_r),
    .size_y        (size_y_r),
    .size_z        (size_z_r),
    .cell_centered (cell_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_grad_x    (out_grad_x),
    .out_grad_y    (out_grad_y),
    .out_grad_z    (out_grad_z),
    .out_status    (out_status)
  );

endmodule

// ----- verif/rgg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgg_checker
// Watches the input, result and configuration ports of the grid gradient
// block, predicts the gradient beat for every accepted input beat and
// compares accepted result beats with the oldest prediction.
// ----------------------------------------------------------------------------
module rgg_checker
  import rgg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CW-1:0]        in_command,
  input  logic [IW-1:0]        in_index_i,
  input  logic [JW-1:0]        in_index_j,
  input  logic [KW-1:0]        in_index_k,
  input  logic signed [DW-1:0] in_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [DW-1:0] out_grad_x,
  input  logic signed [DW-1:0] out_grad_y,
  input  logic signed [DW-1:0] out_grad_z,
  input  logic [STW-1:0]       out_status,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output int                   fail_cnt,
  output int                   grads_owed
);

  typedef struct packed {
    logic [DW-1:0]  gx;
    logic [DW-1:0]  gy;
    logic [DW-1:0]  gz;
    logic [STW-1:0] st;
  } grad_beat_t;

  // shadow copy of configuration and stores
  logic [NW-1:0] sz_x, sz_y, sz_z;
  logic          cell_mode;
  logic [DW-1:0] xc [CDEPTH];
  logic [DW-1:0] yc [CDEPTH];
  logic [DW-1:0] zc [CDEPTH];
  logic [DW-1:0] smp [SDEPTH];

  grad_beat_t grad_q [$];

  initial begin
    fail_cnt   = 0;
    grads_owed = 0;
    foreach (xc[n]) begin
      xc[n] = '0;
      yc[n] = '0;
      zc[n] = '0;
    end
    foreach (smp[n]) smp[n] = '0;
  end

  function automatic longint crd(input int ax, input int idx);
    logic [DW-1:0] c;
    case (ax)
      0:       c = xc[idx];
      1:       c = yc[idx];
      default: c = zc[idx];
    endcase
    return longint'($signed(c));
  endfunction

  function automatic longint smp_at(input int i, input int j, input int k);
    return longint'($signed(smp[(k * MAX_Y + j) * MAX_X + i]));
  endfunction

  function automatic int clampn(input logic [NW-1:0] v, input int lo, input int hi);
    if (int'(v) < lo) return lo;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // one gradient component along an axis; sets the zero-span / saturation flags
  function automatic longint axis_grad(input int ax, input int n, input int p,
                                       input int i, input int j, input int k,
                                       inout bit zf, inout bit sf);
    int lo, hi;
    longint s_lo, s_hi, span2, q;
    lo = (p == 0) ? 0 : ((p == n - 1) ? n - 2 : p - 1);
    hi = (p == 0) ? 1 : ((p == n - 1) ? n - 1 : p + 1);
    case (ax)
      0: begin
        s_lo = smp_at(lo, j, k);
        s_hi = smp_at(hi, j, k);
      end
      1: begin
        s_lo = smp_at(i, lo, k);
        s_hi = smp_at(i, hi, k);
      end
      default: begin
        s_lo = smp_at(i, j, lo);
        s_hi = smp_at(i, j, hi);
      end
    endcase
    if (cell_mode)
      span2 = (crd(ax, hi) + crd(ax, hi + 1)) - (crd(ax, lo) + crd(ax, lo + 1));
    else
      span2 = 2 * (crd(ax, hi) - crd(ax, lo));
    if (span2 == 0) begin
      zf = 1'b1;
      return 0;
    end
    q = ((s_hi - s_lo) * 131072) / span2;
    if (q > 64'sd2147483647) begin
      sf = 1'b1;
      return 64'sd2147483647;
    end
    if (q < -64'sd2147483648) begin
      sf = 1'b1;
      return -64'sd2147483648;
    end
    return q;
  endfunction

  // apply one input beat to the shadow state and work out its result beat
  function automatic grad_beat_t gradient_of(input logic [CW-1:0] cmd, input int i,
                                             input int j, input int k,
                                             input logic [DW-1:0] v);
    grad_beat_t r;
    int nx, ny, nz;
    bit zf, sf;
    r  = '0;
    zf = 1'b0;
    sf = 1'b0;
    case (cmd)
      CMD_LDX: if (i <= MAX_X) xc[i] = v; else r.st = ST_RANGE;
      CMD_LDY: if (i <= MAX_Y) yc[i] = v; else r.st = ST_RANGE;
      CMD_LDZ: if (i <= MAX_Z) zc[i] = v; else r.st = ST_RANGE;
      CMD_LDS: begin
        if (i < MAX_X && j < MAX_Y && k < MAX_Z) smp[(k * MAX_Y + j) * MAX_X + i] = v;
        else r.st = ST_RANGE;
      end
      CMD_QUERY: begin
        nx = clampn(sz_x, 2, MAX_X);
        ny = clampn(sz_y, 2, MAX_Y);
        nz = clampn(sz_z, 1, MAX_Z);
        if (i >= nx || j >= ny || k >= nz) begin
          r.st = ST_RANGE;
        end else begin
          r.gx = DW'(axis_grad(0, nx, i, i, j, k, zf, sf));
          r.gy = DW'(axis_grad(1, ny, j, i, j, k, zf, sf));
          if (nz > 1) r.gz = DW'(axis_grad(2, nz, k, i, j, k, zf, sf));
          if (zf) r.st = ST_ZERO;
          else if (sf) r.st = ST_SAT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    grad_beat_t e;
    if (!rst_n) begin
      sz_x      <= NW'(32);
      sz_y      <= NW'(32);
      sz_z      <= NW'(1);
      cell_mode <= 1'b0;
      grad_q.delete();
      grads_owed <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SIZE_X: sz_x <= pwdata[NW-1:0];
          REG_SIZE_Y: sz_y <= pwdata[NW-1:0];
          REG_SIZE_Z: sz_z <= pwdata[NW-1:0];
          REG_CELL:   cell_mode <= pwdata[0];
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (grad_q.size() == 0) begin
          $display("%0t: unexpected result beat gx=%h gy=%h gz=%h st=%0d", $time,
                   out_grad_x, out_grad_y, out_grad_z, out_status);
          fail_cnt++;
        end else begin
          e = grad_q.pop_front();
          if (out_grad_x !== e.gx) begin
            $display("%0t: grad_x expected %h actual %h", $time, e.gx, out_grad_x);
            fail_cnt++;
          end
          if (out_grad_y !== e.gy) begin
            $display("%0t: grad_y expected %h actual %h", $time, e.gy, out_grad_y);
            fail_cnt++;
          end
          if (out_grad_z !== e.gz) begin
            $display("%0t: grad_z expected %h actual %h", $time, e.gz, out_grad_z);
            fail_cnt++;
          end
          if (out_status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
            fail_cnt++;
          end
        end
      end
      // input beat
      if (in_valid && !in_stall)
        grad_q.push_back(gradient_of(in_command, int'(in_index_i), int'(in_index_j),
                                     int'(in_index_k), in_value));
      grads_owed <= grad_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the grid gradient block: loads coordinates and samples so that
// every query only touches written entries, walks several grid settings over
// the config port, and mixes in range errors, unknown commands and noise.
// ----------------------------------------------------------------------------
module tb;
  import rgg_pkg::*;

  localparam int WDOG_LIMIT = 5000;
  localparam int ITEMS      = 1850;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CW-1:0]        in_command;
  logic [IW-1:0]        in_index_i;
  logic [JW-1:0]        in_index_j;
  logic [KW-1:0]        in_index_k;
  logic signed [DW-1:0] in_value;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_grad_x, out_grad_y, out_grad_z;
  logic [STW-1:0]       out_status;
  logic                 psel, penable, pwrite;
  logic [3:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  int                   fail_cnt;
  int                   grads_owed;

  // what has been written so far, so no query reads an unwritten entry
  bit crd_done [3][CDEPTH];
  bit smp_done [SDEPTH];
  int nx, ny, nz;
  bit cell_on;
  int beats_sent;
  bit no_gaps;
  int wdog;

  rectilinear_grid_gradient dut (.*);

  rgg_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_index_i, .in_index_j,
    .in_index_k, .in_value, .out_valid, .out_stall, .out_grad_x, .out_grad_y,
    .out_grad_z, .out_status, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_cnt, .grads_owed
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side stall pattern: mostly short, some long, some clear stretches
  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      end else begin
        out_stall = 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      end
    end
  end

  // watchdog on cycles with no accepted beat and no config access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int clampn(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [CW-1:0] load_cmd(input int ax);
    case (ax)
      0:       return CMD_LDX;
      1:       return CMD_LDY;
      default: return CMD_LDZ;
    endcase
  endfunction

  function automatic logic [DW-1:0] sample_val();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return DW'($urandom_range(0, 3)) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // coordinate values: duplicates give zero spans, tiny spans give saturation
  function automatic logic [DW-1:0] coord_val(input int idx);
    case ($urandom_range(0, 5))
      0:       return DW'($urandom_range(0, 3)) << 16;
      1:       return $urandom();
      2:       return DW'($urandom_range(0, 255));
      default: return (DW'(idx) << 16) + DW'($urandom_range(0, 40000));
    endcase
  endfunction

  task automatic send_beat(input logic [CW-1:0] cmd, input int i, input int j,
                           input int k, input logic [DW-1:0] v);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        9:             gap = $urandom_range(10, 40);
        default:       gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_command = cmd;
    in_index_i = IW'(i);
    in_index_j = JW'(j);
    in_index_k = KW'(k);
    in_value   = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // track writes that land in the stores
    if (cmd == CMD_LDX || cmd == CMD_LDY || cmd == CMD_LDZ) begin
      if (i < CDEPTH) crd_done[int'(cmd)][i] = 1'b1;
    end else if (cmd == CMD_LDS && i < MAX_X) begin
      smp_done[(k * MAX_Y + j) * MAX_X + i] = 1'b1;
    end
    beats_sent++;
  endtask

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    psel     = 1'b1;
    pwrite   = 1'b1;
    penable  = 1'b0;
    paddr    = {reg_idx, 2'b00};
    pwdata   = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (grads_owed != 0 || (in_valid && !in_stall)) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // load every coordinate and neighbor sample that a query at (i,j,k) reads
  task automatic prepare_point(input int i, input int j, input int k);
    int n, p, lo, hi;
    for (int ax = 0; ax < 3; ax++) begin
      n = (ax == 0) ? nx : ((ax == 1) ? ny : nz);
      p = (ax == 0) ? i : ((ax == 1) ? j : k);
      if (n > 1) begin
        lo = (p == 0) ? 0 : ((p == n - 1) ? n - 2 : p - 1);
        hi = (p == 0) ? 1 : ((p == n - 1) ? n - 1 : p + 1);
        for (int c = lo; c <= hi + 1; c++)
          if (!crd_done[ax][c] && (c == lo || c == hi || cell_on))
            send_beat(load_cmd(ax), c, 0, 0, coord_val(c));
        for (int s = lo; s <= hi; s += hi - lo) begin
          case (ax)
            0: if (!smp_done[(k * MAX_Y + j) * MAX_X + s])
                 send_beat(CMD_LDS, s, j, k, sample_val());
            1: if (!smp_done[(k * MAX_Y + s) * MAX_X + i])
                 send_beat(CMD_LDS, i, s, k, sample_val());
            default: if (!smp_done[(s * MAX_Y + j) * MAX_X + i])
                 send_beat(CMD_LDS, i, j, s, sample_val());
          endcase
        end
      end
    end
  endtask

  task automatic query_at(input int i, input int j, input int k);
    prepare_point(i, j, k);
    send_beat(CMD_QUERY, i, j, k, $urandom());
  endtask

  function automatic int pick_pos(input int n);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic set_grid(input int sx, input int sy, input int sz, input bit cm);
    apb_write(REG_SIZE_X, 32'(sx));
    apb_write(REG_SIZE_Y, 32'(sy));
    apb_write(REG_SIZE_Z, 32'(sz));
    apb_write(REG_CELL, 32'(cm));
    nx      = clampn(sx, 2, MAX_X);
    ny      = clampn(sy, 2, MAX_Y);
    nz      = clampn(sz, 1, MAX_Z);
    cell_on = cm;
  endtask

  task automatic random_beats(input int quota);
    int stop_at, i, j, k, ax;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send_beat(CMD_LDS, $urandom_range(0, 63), $urandom_range(0, 31),
                    $urandom_range(0, 31), sample_val());
        end
        2, 3: begin
          i = $urandom_range(0, 63);
          j = $urandom_range(0, 31);
          k = $urandom_range(0, 31);
          if (i >= nx) ;
          else if (j >= ny && ny < 32) ;
          else if (k >= nz && nz < 32) ;
          else i = $urandom_range(nx, 63);
          send_beat(CMD_QUERY, i, j, k, $urandom());
        end
        4, 5: begin
          ax = $urandom_range(0, 2);
          i  = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
          send_beat(load_cmd(ax), i, $urandom_range(0, 31), $urandom_range(0, 31),
                    coord_val(i));
        end
        6: begin
          send_beat(CW'($urandom_range(5, 7)), $urandom_range(0, 63),
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom());
        end
        7, 8: begin
          // refresh the sample at an in-range point, then query around it
          i = pick_pos(nx);
          j = pick_pos(ny);
          k = pick_pos(nz);
          send_beat(CMD_LDS, i, j, k, sample_val());
          query_at(i, j, k);
        end
        default: query_at(pick_pos(nx), pick_pos(ny), pick_pos(nz));
      endcase
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_LDX;
    in_index_i = '0;
    in_index_j = '0;
    in_index_k = '0;
    in_value   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    beats_sent = 0;
    no_gaps    = 1'b0;
    wdog       = 0;
    nx      = 32;
    ny      = 32;
    nz      = 1;
    cell_on = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset grid, corners, zero span, saturation, bad indices, unknown command
    query_at(0, 0, 0);
    query_at(31, 31, 0);
    send_beat(CMD_QUERY, 0, 0, 1, 32'h0);
    send_beat(CMD_QUERY, 32, 0, 0, 32'h0);
    send_beat(CMD_LDS, 63, 31, 31, 32'hffff_ffff);
    send_beat(CMD_LDX, 33, 0, 0, 32'h1234_5678);
    send_beat(CMD_LDZ, 63, 0, 0, 32'h1);
    send_beat(3'd7, 63, 31, 31, 32'hffff_ffff);
    query_at(0, 5, 0);
    send_beat(CMD_LDX, 0, 0, 0, 32'h0001_0000);
    send_beat(CMD_LDX, 1, 0, 0, 32'h0001_0000);
    send_beat(CMD_QUERY, 0, 5, 0, 32'h0);
    query_at(0, 6, 0);
    send_beat(CMD_LDX, 1, 0, 0, 32'h0001_0001);
    send_beat(CMD_LDS, 0, 6, 0, 32'h8000_0000);
    send_beat(CMD_LDS, 1, 6, 0, 32'h7fff_ffff);
    send_beat(CMD_QUERY, 0, 6, 0, 32'h0);
    send_beat(CMD_LDS, 0, 6, 0, 32'h7fff_ffff);
    send_beat(CMD_LDS, 1, 6, 0, 32'h8000_0000);
    send_beat(CMD_QUERY, 0, 6, 0, 32'h0);
    random_beats(250);
    // the sender holds off until every pending result is back
    drain();

    set_grid(2, 2, 1, 1'b0);
    random_beats(250);
    drain();
    no_gaps = 1'b1;
    set_grid(32, 32, 32, 1'b1);
    query_at(31, 31, 31);
    query_at(0, 0, 31);
    random_beats(300);
    drain();
    no_gaps = 1'b0;
    set_grid(5, 7, 4, 1'b1);
    random_beats(300);
    drain();
    set_grid(0, 63, 0, 1'b0);
    random_beats(250);
    drain();
    set_grid(63, 1, 40, 1'b1);
    while (beats_sent < ITEMS) random_beats(50);
    drain();

    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
